### sv/iwqc_pkg.sv
// Package with shared types and constants of the IPC window quota controller.
package iwqc_pkg;

    // Action codes reported with each result item.
    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_OVER   = 3'd1,
        ACT_INC    = 3'd2,
        ACT_HALVE  = 3'd3,
        ACT_UNDER  = 3'd4,
        ACT_HOLD   = 3'd5
    } t_action;

    // Configuration register indexes.
    localparam logic [2:0] REG_WINDOW_SIZE = 3'd0;
    localparam logic [2:0] REG_QUOTA_STEP  = 3'd1;
    localparam logic [2:0] REG_MIN_QUOTA   = 3'd2;
    localparam logic [2:0] REG_MAX_QUOTA   = 3'd3;
    localparam logic [2:0] REG_STD_FACTOR  = 3'd4;
    localparam logic [2:0] REG_RUN_TICKS   = 3'd5;
    localparam logic [2:0] REG_APPLY_EN    = 3'd6;

    // Request and response between the sequencer and the shared divide/sqrt unit.
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [31:0] den;
    } t_calc_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_calc_rsp;

endpackage

### sv/iwqc_calc.sv
// Shared iterative unit: restoring divider or integer square root, one bit per cycle.
module iwqc_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iwqc_pkg::t_calc_req i_req,
    output iwqc_pkg::t_calc_rsp o_rsp
);

    logic [63:0] r_num;
    logic [31:0] r_den;
    logic [64:0] r_rem;
    logic [63:0] r_quo;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_sqrt;
    logic        r_done;

    logic [64:0] n_rem_sh;
    logic [64:0] n_trial;
    logic        n_ge;

    // One step: shift in one (div) or two (sqrt) bits and try to subtract.
    always_comb begin
        if (r_sqrt) begin
            n_rem_sh = {r_rem[62:0], r_num[63:62]};
            n_trial  = {r_quo[62:0], 2'b01};
        end else begin
            n_rem_sh = {r_rem[63:0], r_num[63]};
            n_trial  = {33'd0, r_den};
        end
        n_ge = (n_rem_sh >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.is_sqrt;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= i_req.is_sqrt ? 7'd32 : 7'd64;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_rem_sh - n_trial : n_rem_sh;
                r_quo <= {r_quo[62:0], n_ge};
                r_num <= r_sqrt ? {r_num[61:0], 2'b00} : {r_num[62:0], 1'b0};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_quo;

endmodule

### sv/ipc_window_quota_controller_core.sv
// Top level of the IPC window quota controller.
// Usage: one IPC sample (unsigned Q4.12, zero = no measurement) enters per item on
// the s_axis channel; one result item leaves on m_axis for every sample.
// Registers are to be written through the cfg channel (index and data) while idle;
// the block itself does not enforce this. A control-mode or invalid sample is
// evaluated, then output. A fill-mode sample runs the shared divide/sqrt unit
// three times: mean divide, variance divide and square root, with a hand-off
// after each run, then a bound step and the output step. The shared unit works
// one bit per cycle. One sample is in work at a time; s_axis_tready is low until
// the result is taken, and the next sample can be accepted in the cycle after
// that. When the receiver stalls, the result holds in its output register and
// no new sample is accepted.
// Reset (synchronous, active low) restores register defaults, clears the window
// and bounds, enters fill mode and loads the quota and tick count.
// Before the first sample, a write to any configuration register reloads the
// quota and the countdown.
module ipc_window_quota_controller_core #(
    parameter int MAX_WINDOW = 256,
    parameter int QUOTA_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] ipc_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [23:0] quota, [26:24] action, [27] apply_quota,
                                        // [28] refilling, [29] done_res,
                                        // [30] quota_unlimited, [31] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam logic [QUOTA_BITS-1:0] QMAX = '1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EVAL  = 7'b0000010,
        ST_MEAN  = 7'b0000100,
        ST_VAR   = 7'b0001000,
        ST_SQRT  = 7'b0010000,
        ST_BOUND = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [8:0]  r_window_size;
    logic [23:0] r_quota_step, r_min_quota, r_max_quota;
    logic [11:0] r_std_factor;
    logic [31:0] r_run_ticks;
    logic        r_apply_en;

    // Block state.
    logic [CW-1:0]  r_count;
    logic [23:0]    r_sum;
    logic [39:0]    r_sum_sq;
    logic [15:0]    r_mean, r_std;
    logic [23:0]    r_top, r_upper, r_stable, r_bottom;
    logic [QUOTA_BITS-1:0] r_quota;
    logic           r_refill, r_seen, r_done_run, r_started;
    logic [32:0]    r_ticks;
    logic [15:0]    r_ipc;
    logic           r_expired;
    logic [31:0]    r_msq;
    logic [31:0]    r_m_data;
    logic           r_m_valid;
    iwqc_pkg::t_action r_act;

    iwqc_pkg::t_calc_req calc_req;
    iwqc_pkg::t_calc_rsp calc_rsp;

    iwqc_calc u_calc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (calc_req),
        .o_rsp  (calc_rsp)
    );

    // Saturated config values and effective window.
    logic [QUOTA_BITS-1:0] min_q, max_q, step_q;
    logic [CW-1:0]         eff_win;
    logic [QUOTA_BITS:0]   inc_sum;
    logic [QUOTA_BITS-1:0] inc_q, half_q;
    logic [23:0]           ipc24;
    logic                  cfg_fire, in_fire;

    function automatic logic [QUOTA_BITS-1:0] qsat24(input logic [23:0] v);
        logic [31:0] w;
        w = {8'd0, v};
        if (w > 32'(QMAX)) return QMAX;
        return w[QUOTA_BITS-1:0];
    endfunction

    always_comb begin
        min_q  = qsat24(r_min_quota);
        max_q  = qsat24(r_max_quota);
        step_q = qsat24(r_quota_step);
        if (r_window_size == 9'd0)
            eff_win = CW'(1);
        else if ({23'd0, r_window_size} > 32'(MAX_WINDOW))
            eff_win = CW'(MAX_WINDOW);
        else
            eff_win = CW'(r_window_size);
        inc_sum = {1'b0, r_quota} + {1'b0, step_q};
        inc_q   = (inc_sum < {1'b0, max_q}) ? inc_sum[QUOTA_BITS-1:0] : max_q;
        half_q  = (r_quota >> 1) > min_q ? (r_quota >> 1) : min_q;
        ipc24   = {8'd0, r_ipc};
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_m_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_fire      = i_cfg_valid && o_cfg_ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Requests to the shared unit.
    logic [63:0] quo;
    logic [31:0] dscale;
    logic [23:0] n_d;
    logic [35:0] fac_prod;
    assign quo = calc_rsp.result;
    assign fac_prod = {24'd0, r_std_factor} * {20'd0, r_std};
    assign n_d = fac_prod[31:8];

    always_comb begin
        calc_req = '0;
        unique case (r_state)
            ST_EVAL: begin
                calc_req.start = !r_done_run && r_ipc != 16'd0 && r_refill;
                calc_req.num   = {40'd0, r_sum + ipc24};
                calc_req.den   = 32'(r_count) + 32'd1;
            end
            ST_MEAN: begin
                calc_req.start = calc_rsp.done;
                calc_req.num   = {24'd0, r_sum_sq};
                calc_req.den   = 32'(r_count);
            end
            ST_VAR: begin
                calc_req.start   = calc_rsp.done;
                calc_req.is_sqrt = 1'b1;
                calc_req.num     = ({24'd0, quo[39:0]} > {32'd0, r_msq})
                                 ? {24'd0, quo[39:0]} - {32'd0, r_msq} : 64'd0;
            end
            default: ;
        endcase
    end
    assign dscale = 32'(r_count);

    logic [24:0] two_d;
    assign two_d = {n_d, 1'b0};

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_window_size <= 9'd16;
            r_quota_step  <= 24'd5000;
            r_min_quota   <= 24'd10000;
            r_max_quota   <= 24'd100000;
            r_std_factor  <= 12'd256;
            r_run_ticks   <= 32'd3600;
            r_apply_en    <= 1'b1;
            r_count       <= '0;
            r_sum         <= '0;
            r_sum_sq      <= '0;
            r_mean        <= '0;
            r_std         <= '0;
            r_top         <= '0;
            r_upper       <= '0;
            r_stable      <= '0;
            r_bottom      <= '0;
            r_quota       <= QUOTA_BITS'(10000);
            r_refill      <= 1'b1;
            r_seen        <= 1'b0;
            r_done_run    <= 1'b0;
            r_started     <= 1'b0;
            r_ticks       <= 33'd3600;
            r_m_valid     <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready) r_m_valid <= 1'b0;
            // Configuration writes; reload start values before the first sample.
            if (cfg_fire) begin
                logic [23:0] n_min, n_max;
                logic        n_en;
                logic [31:0] n_rt;
                n_min = r_min_quota; n_max = r_max_quota;
                n_en = r_apply_en; n_rt = r_run_ticks;
                unique case (i_cfg_index)
                    iwqc_pkg::REG_WINDOW_SIZE: r_window_size <= i_cfg_data[8:0];
                    iwqc_pkg::REG_QUOTA_STEP:  r_quota_step  <= i_cfg_data[23:0];
                    iwqc_pkg::REG_MIN_QUOTA:   n_min         = i_cfg_data[23:0];
                    iwqc_pkg::REG_MAX_QUOTA:   n_max         = i_cfg_data[23:0];
                    iwqc_pkg::REG_STD_FACTOR:  r_std_factor  <= i_cfg_data[11:0];
                    iwqc_pkg::REG_RUN_TICKS:   n_rt          = i_cfg_data;
                    iwqc_pkg::REG_APPLY_EN:    n_en          = i_cfg_data[0];
                    default: ;
                endcase
                r_min_quota <= n_min; r_max_quota <= n_max;
                r_apply_en <= n_en; r_run_ticks <= n_rt;
                if (!r_started && i_cfg_index <= iwqc_pkg::REG_APPLY_EN) begin
                    r_quota <= n_en ? qsat24(n_min) : qsat24(n_max);
                    r_ticks <= {1'b0, n_rt};
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_ipc   <= s_axis_tdata;
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    // Tick countdown; an expired count ends the run here unless the sample is a nonzero fill-mode one.
                    if (!r_done_run) begin
                        r_started <= 1'b1;
                        r_expired <= (r_ticks == 33'd0);
                        if (r_ticks != 33'd0) r_ticks <= r_ticks - 33'd1;
                        else if (!(r_ipc != 16'd0 && r_refill)) r_done_run <= 1'b1;
                    end
                    if (r_done_run || r_ipc == 16'd0) begin
                        r_act   <= iwqc_pkg::ACT_NONE;
                        r_state <= ST_OUT;
                    end else if (r_refill) begin
                        r_act    <= iwqc_pkg::ACT_NONE;
                        r_count  <= r_count + CW'(1);
                        r_sum    <= r_sum + ipc24;
                        r_sum_sq <= r_sum_sq + 40'({16'd0, r_ipc} * {16'd0, r_ipc});
                        r_state  <= ST_MEAN;
                    end else begin
                        r_state <= ST_OUT;
                        if (ipc24 > r_top) begin
                            r_act <= iwqc_pkg::ACT_OVER;
                            r_quota <= min_q; r_refill <= 1'b1;
                            r_count <= '0; r_sum <= '0; r_sum_sq <= '0;
                            r_mean <= '0; r_std <= '0;
                        end else if (ipc24 >= r_stable && ipc24 <= r_upper) begin
                            r_act <= iwqc_pkg::ACT_INC;
                            r_quota <= inc_q;
                        end else if (ipc24 >= r_bottom && ipc24 < r_stable) begin
                            r_act <= iwqc_pkg::ACT_HALVE;
                            r_quota <= half_q;
                        end else if (ipc24 < r_bottom) begin
                            r_act <= iwqc_pkg::ACT_UNDER;
                            r_quota <= min_q; r_refill <= 1'b1;
                            r_count <= '0; r_sum <= '0; r_sum_sq <= '0;
                            r_mean <= '0; r_std <= '0;
                        end else begin
                            r_act <= iwqc_pkg::ACT_HOLD;
                        end
                    end
                end
                ST_MEAN: begin
                    if (calc_rsp.done) begin
                        r_mean  <= quo[15:0];
                        r_msq   <= {16'd0, quo[15:0]} * {16'd0, quo[15:0]};
                        r_state <= ST_VAR;
                    end
                end
                ST_VAR: begin
                    if (calc_rsp.done) r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (calc_rsp.done) begin
                        r_std   <= quo[15:0];
                        r_state <= ST_BOUND;
                    end
                end
                ST_BOUND: begin
                    if (dscale >= 32'(eff_win)) begin
                        r_top    <= 24'({8'd0, r_mean} + two_d);
                        r_upper  <= {8'd0, r_mean} + n_d;
                        r_stable <= ({8'd0, r_mean} > n_d) ? {8'd0, r_mean} - n_d : 24'd0;
                        r_bottom <= ({9'd0, r_mean} > two_d)
                                  ? 24'({9'd0, r_mean} - two_d) : 24'd0;
                        r_refill <= 1'b0;
                        if (!r_expired) r_seen <= 1'b1;
                    end
                    if (r_expired) r_done_run <= 1'b1;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_m_valid <= 1'b1;
                    r_m_data  <= {1'b0, r_done_run && r_seen, r_done_run, r_refill,
                                  (r_act != iwqc_pkg::ACT_NONE) && (r_act != iwqc_pkg::ACT_HOLD)
                                      && r_apply_en,
                                  r_act, 24'(r_quota)};
                    r_state   <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("sample accepted while busy");
    a_out_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == ST_OUT))
        else $error("result without sequence end");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_WINDOW))
        else $error("window count overflow");
`endif

endmodule

### test/iwqc_checker.sv
// Checker for the IPC window quota controller: predicts every result item and compares it.
`timescale 1ns / 100ps

module iwqc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_result_count
);

    localparam int          MAX_WIN   = 256;
    localparam longint unsigned QUOTA_TOP = 64'hFF_FFFF;

    typedef struct {
        logic [23:0]       quota;
        iwqc_pkg::t_action action;
        logic              apply_quota;
        logic              refilling;
        logic              done_res;
        logic              quota_unlimited;
    } t_quota_result;

    // Register copies.
    longint unsigned win_size, step_amt, quota_lo, quota_hi, dev_mult, tick_budget;
    logic            apply_en;

    // Controller state.
    longint unsigned n_samples, acc_sum, acc_sq, win_mean, win_std;
    longint unsigned bnd_top, bnd_upper, bnd_stable, bnd_bottom;
    longint unsigned quota_now, ticks_rem;
    logic            in_refill, first_window_seen, finished, run_started;

    t_quota_result   pending_results[$];

    function automatic longint unsigned clip_quota(longint unsigned v);
        return (v > QUOTA_TOP) ? QUOTA_TOP : v;
    endfunction

    // Integer square root, digit by digit.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void load_start_values();
        quota_now = apply_en ? clip_quota(quota_lo) : clip_quota(quota_hi);
        ticks_rem = tick_budget;
    endfunction

    function automatic void clear_window();
        n_samples = 0;
        acc_sum   = 0;
        acc_sq    = 0;
        win_mean  = 0;
        win_std   = 0;
    endfunction

    function automatic void reset_model();
        win_size    = 16;
        step_amt    = 5000;
        quota_lo    = 10000;
        quota_hi    = 100000;
        dev_mult    = 256;
        tick_budget = 3600;
        apply_en    = 1'b1;
        clear_window();
        bnd_top    = 0;
        bnd_upper  = 0;
        bnd_stable = 0;
        bnd_bottom = 0;
        in_refill         = 1'b1;
        first_window_seen = 1'b0;
        finished          = 1'b0;
        run_started       = 1'b0;
        load_start_values();
    endfunction

    function automatic void write_register(logic [2:0] idx, logic [31:0] val);
        case (idx)
            iwqc_pkg::REG_WINDOW_SIZE: win_size    = val[8:0];
            iwqc_pkg::REG_QUOTA_STEP:  step_amt    = val[23:0];
            iwqc_pkg::REG_MIN_QUOTA:   quota_lo    = val[23:0];
            iwqc_pkg::REG_MAX_QUOTA:   quota_hi    = val[23:0];
            iwqc_pkg::REG_STD_FACTOR:  dev_mult    = val[11:0];
            iwqc_pkg::REG_RUN_TICKS:   tick_budget = val;
            iwqc_pkg::REG_APPLY_EN:    apply_en    = val[0];
            default:                   return;
        endcase
        if (!run_started) load_start_values();
    endfunction

    // Works out the result item caused by one sample and queues it.
    function automatic void predict_quota(logic [15:0] ipc_in);
        longint unsigned   ipc, n_eff, var_v, sq, dev, sum_q;
        iwqc_pkg::t_action act;
        logic              expired;
        t_quota_result     r;
        ipc     = ipc_in;
        act     = iwqc_pkg::ACT_NONE;
        expired = 1'b0;
        if (!finished) begin
            run_started = 1'b1;
            if (ticks_rem == 0) expired = 1'b1;
            else ticks_rem = ticks_rem - 1;
            if (ipc != 0) begin
                if (!in_refill) begin
                    if (ipc > bnd_top) begin
                        act       = iwqc_pkg::ACT_OVER;
                        quota_now = clip_quota(quota_lo);
                        in_refill = 1'b1;
                        clear_window();
                    end else if (ipc >= bnd_stable && ipc <= bnd_upper) begin
                        act       = iwqc_pkg::ACT_INC;
                        sum_q     = quota_now + step_amt;
                        quota_now = clip_quota(sum_q < clip_quota(quota_hi) ?
                                               sum_q : clip_quota(quota_hi));
                    end else if (ipc >= bnd_bottom && ipc < bnd_stable) begin
                        act       = iwqc_pkg::ACT_HALVE;
                        quota_now = ((quota_now >> 1) > clip_quota(quota_lo)) ?
                                    (quota_now >> 1) : clip_quota(quota_lo);
                    end else if (ipc < bnd_bottom) begin
                        act       = iwqc_pkg::ACT_UNDER;
                        quota_now = clip_quota(quota_lo);
                        in_refill = 1'b1;
                        clear_window();
                    end else begin
                        act = iwqc_pkg::ACT_HOLD;
                    end
                end else begin
                    // Fill mode: running statistics over the window.
                    n_eff = (win_size == 0) ? 1 : ((win_size > MAX_WIN) ? MAX_WIN : win_size);
                    n_samples = n_samples + 1;
                    acc_sum   = acc_sum + ipc;
                    acc_sq    = acc_sq + ipc * ipc;
                    win_mean  = acc_sum / n_samples;
                    sq        = win_mean * win_mean;
                    var_v     = acc_sq / n_samples;
                    var_v     = (var_v > sq) ? var_v - sq : 0;
                    win_std   = int_sqrt(var_v) & 64'hFFFF;
                    if (n_samples >= n_eff) begin
                        dev        = (dev_mult * win_std) >> 8;
                        bnd_top    = win_mean + 2 * dev;
                        bnd_upper  = win_mean + dev;
                        bnd_stable = (win_mean > dev) ? win_mean - dev : 0;
                        bnd_bottom = (win_mean > 2 * dev) ? win_mean - 2 * dev : 0;
                        in_refill  = 1'b0;
                        if (!expired) first_window_seen = 1'b1;
                    end
                end
            end
            if (expired) finished = 1'b1;
        end
        r.quota           = quota_now[23:0];
        r.action          = act;
        r.apply_quota     = (act != iwqc_pkg::ACT_NONE && act != iwqc_pkg::ACT_HOLD) && apply_en;
        r.refilling       = in_refill;
        r.done_res        = finished;
        r.quota_unlimited = finished && first_window_seen;
        pending_results = {pending_results, r};
    endfunction

    // Compares one field and counts a mismatch.
    task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        t_quota_result e;
        if (!i_rst_n) begin
            reset_model();
            pending_results.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && i_s_tready) predict_quota(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                o_result_count <= o_result_count + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: result item with nothing expected, actual %h",
                             $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    e = pending_results.pop_front();
                    check_field("quota", e.quota, i_m_tdata[23:0]);
                    check_field("action", e.action, i_m_tdata[26:24]);
                    check_field("apply_quota", e.apply_quota, i_m_tdata[27]);
                    check_field("refilling", e.refilling, i_m_tdata[28]);
                    check_field("done_res", e.done_res, i_m_tdata[29]);
                    check_field("quota_unlimited", e.quota_unlimited, i_m_tdata[30]);
                    check_field("pad bit", 0, i_m_tdata[31]);
                end
            end
        end
    end

endmodule

### test/ipc_window_quota_controller_core_tb.sv
// Testbench top for the IPC window quota controller: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module ipc_window_quota_controller_core_tb;

    localparam int RUN_LENGTH  = 1400;
    localparam int TOTAL_ITEMS = 1450;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int fail_count;
    int result_count;
    int samples_sent;
    int burst_left;
    logic long_hold_req;
    logic long_hold_used;
    int   hold_left;
    int   duty_pct;
    int   duty_cnt;

    ipc_window_quota_controller_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    iwqc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_result_count (result_count)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random ready at a duty cycle re-drawn from 100, 75 or 25 percent, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready  <= 1'b0;
            long_hold_used <= 1'b0;
            hold_left      <= 0;
            duty_pct       <= 100;
            duty_cnt       <= 0;
        end else if (long_hold_req && !long_hold_used) begin
            long_hold_used <= 1'b1;
            hold_left      <= 1500;
            m_axis_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            duty_cnt <= duty_cnt + 1;
            if (duty_cnt % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       duty_pct <= 100;
                    1:       duty_pct <= 75;
                    default: duty_pct <= 25;
                endcase
            end
            m_axis_tready <= ($urandom_range(0, 99) < duty_pct);
        end
    end

    // Keeps cfg valid high; the caller lowers it with cfg_release.
    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one sample, with bursts of random length separated by random gaps.
    task automatic send_sample(logic [15:0] ipc);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ipc;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        samples_sent++;
    endtask

    // Pauses the sender until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (result_count != samples_sent) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    function automatic logic [15:0] near_value(int center, int spread);
        int v;
        v = center + $urandom_range(0, 2 * spread) - spread;
        if (v < 1) v = 1;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    task automatic configure_phase(int ph);
        logic [31:0] ws, q_lo, q_hi, stp, fac;
        case (ph % 6)
            0: ws = $urandom_range(1, 8);
            1: ws = 0;
            2: ws = 256;
            3: ws = $urandom_range(2, 5);
            4: ws = 511;
            default: ws = $urandom_range(1, 12);
        endcase
        if (ph == 2 || ph == 4) ws = (ph == 2) ? 256 : 511;
        if (ph > 6 && (ws == 256 || ws == 511)) ws = 3;
        stp  = (ph == 1) ? 0 : (ph == 3) ? 24'hFFFFFF : $urandom_range(0, 200000);
        q_lo = (ph == 5) ? 24'hFFFFFF : (ph == 1) ? 0 : $urandom_range(0, 50000);
        q_hi = (ph == 5) ? 0 : (ph == 3) ? 24'hFFFFFF : $urandom_range(50000, 400000);
        fac  = (ph == 1) ? 0 : (ph == 3) ? 4095 : $urandom_range(64, 1024);
        cfg_write(iwqc_pkg::REG_WINDOW_SIZE, ws);
        cfg_write(iwqc_pkg::REG_QUOTA_STEP, stp);
        cfg_write(iwqc_pkg::REG_MIN_QUOTA, q_lo);
        cfg_write(iwqc_pkg::REG_MAX_QUOTA, q_hi);
        cfg_write(iwqc_pkg::REG_STD_FACTOR, fac);
        cfg_write(iwqc_pkg::REG_APPLY_EN, (ph % 3 == 1) ? 32'd0 : 32'd1);
        cfg_write(iwqc_pkg::REG_RUN_TICKS, $urandom());
        cfg_release();
    endtask

    // Stimulus: directed cases, then phases of fill windows and control samples.
    initial begin
        int ph, center, spread, n_ctl, pick, k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        long_hold_req = 1'b0;
        samples_sent  = 0;
        burst_left    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Start-up writes reload quota and countdown; the last run-ticks write sets the run length.
        cfg_write(iwqc_pkg::REG_RUN_TICKS, 32'd0);
        cfg_write(iwqc_pkg::REG_RUN_TICKS, 32'hFFFF_FFFF);
        cfg_write(iwqc_pkg::REG_APPLY_EN, 32'd0);
        cfg_write(iwqc_pkg::REG_MAX_QUOTA, 32'd60000);
        cfg_write(iwqc_pkg::REG_APPLY_EN, 32'd1);
        cfg_write(iwqc_pkg::REG_MIN_QUOTA, 32'd1000);
        cfg_write(iwqc_pkg::REG_RUN_TICKS, 32'(RUN_LENGTH));
        cfg_write(iwqc_pkg::REG_WINDOW_SIZE, 32'd1);
        cfg_release();

        // Single-sample window: zero deviation, so every band collapses on the mean.
        send_sample(16'd0);
        send_sample(16'd100);
        send_sample(16'd100);
        send_sample(16'd101);
        send_sample(16'd50);
        send_sample(16'd49);
        send_sample(16'hFFFF);
        send_sample(16'd1);
        drain_results();

        // Two-sample window with spread: hold, increase, halve and over top.
        cfg_write(iwqc_pkg::REG_WINDOW_SIZE, 32'd2);
        cfg_write(iwqc_pkg::REG_STD_FACTOR, 32'd256);
        cfg_release();
        send_sample(16'd1000);
        send_sample(16'd0);
        send_sample(16'd3000);
        send_sample(16'd3500);
        send_sample(16'd2000);
        send_sample(16'd2000);
        send_sample(16'd500);
        send_sample(16'd500);
        send_sample(16'd0);
        send_sample(16'd65535);
        send_sample(16'd4000);
        send_sample(16'd4200);
        send_sample(16'd4100);
        drain_results();

        // Random phases of well-formed windows followed by control traffic.
        ph = 0;
        while (samples_sent < TOTAL_ITEMS) begin
            configure_phase(ph);
            if (ph == 2) long_hold_req <= 1'b1;
            center = $urandom_range(500, 60000);
            spread = $urandom_range(0, 4000);
            n_ctl  = $urandom_range(20, 60);
            for (k = 0; k < 600 && samples_sent < TOTAL_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_sample(16'd0);
                else if (pick < 10)
                    send_sample(16'($urandom_range(0, 65535)));
                else if (pick < 80)
                    send_sample(near_value(center, spread));
                else
                    send_sample(near_value(center, 3 * spread + 1));
                if (k >= n_ctl && k >= 300) break;
                if (ph != 2 && ph != 4 && k >= n_ctl + 20) break;
            end
            drain_results();
            ph++;
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #100ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
sv/iwqc_pkg.sv
sv/iwqc_calc.sv
sv/ipc_window_quota_controller_core.sv
test/iwqc_checker.sv
test/ipc_window_quota_controller_core_tb.sv
